// ----- rtl/core/cdcc_pkg.sv -----
// Shared types and constants for the convolution descriptor checker.
// No dependencies; imported by every module of the block.
package cdcc_pkg;

  localparam int InWidth   = 72;
  localparam int OutWidth  = 112;
  localparam int SizeWidth = 54;
  localparam logic [7:0] ConvMagic = 8'hc3;

  typedef enum logic [1:0] {
    OP_SLOT     = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_READ     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e_t;

  typedef enum logic [4:0] {
    ERR_NONE       = 5'd0,
    ERR_BUSY       = 5'd1,
    ERR_UNSUP      = 5'd2,
    ERR_SEQ        = 5'd3,
    ERR_DMEM       = 5'd4,
    ERR_ABI        = 5'd5,
    ERR_MAGIC      = 5'd6,
    ERR_START      = 5'd7,
    ERR_PAD        = 5'd8,
    ERR_STRIDE     = 5'd9,
    ERR_CUTBIT     = 5'd10,
    ERR_KSIZE      = 5'd11,
    ERR_RSV_SHAPE  = 5'd12,
    ERR_RSV_CTRL   = 5'd13,
    ERR_SHAPE      = 5'd14,
    ERR_SHAPE_OVF  = 5'd15,
    ERR_ADDR_OVF   = 5'd16,
    ERR_ADDR_RANGE = 5'd17,
    ERR_BIAS       = 5'd18,
    ERR_OVERLAP    = 5'd19
  } err_e_t;

  // Register indexes of the configuration port.
  localparam logic RegDmBase = 1'b0;
  localparam logic RegDmSize = 1'b1;

  // Last step of each sequenced phase.
  localparam logic [2:0] MulLast   = 3'd5;
  localparam logic [2:0] RangeLast = 3'd3;
  localparam logic [2:0] OvlpLast  = 3'd5;

  typedef struct packed {
    logic       load;
    logic       decode;
    logic       mul;
    logic       range;
    logic       ovlp;
    logic       emit;
    logic [2:0] step;
  } cmd_t;

  typedef struct packed {
    logic out_full;
    logic chk_go;
    logic fail;
  } status_t;

  // Tensor pairs for the overlap pass, in check order.
  function automatic logic [1:0] pair_lo(input logic [2:0] k);
    case (k)
      3'd0, 3'd1, 3'd2: pair_lo = 2'd0;
      3'd3, 3'd4:       pair_lo = 2'd1;
      default:          pair_lo = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] pair_hi(input logic [2:0] k);
    case (k)
      3'd0:       pair_hi = 2'd1;
      3'd1, 3'd3: pair_hi = 2'd2;
      default:    pair_hi = 2'd3;
    endcase
  endfunction

endpackage

// ----- rtl/core/conv_descriptor_csr_checker.sv -----
// Top level of the convolution descriptor checker.
// Instantiates cdcc_ctrl and cdcc_dp; depends on cdcc_pkg.
//
// Checks a 3x3 convolution job descriptor written as four 64-bit slots in
// order 1..4, and serves complete, shadow-read and clear-all requests. One
// item is taken at a time and gives exactly one result item. A slot 4
// write whose fields pass goes through decode, six steps of the shared
// 34x22 multiplier that form the input and output tensor byte sizes, one
// range step per tensor (four) and one overlap step per tensor pair (six);
// the first failing step ends the check. Any other request goes from
// decode straight to the result. A new item is accepted once the previous
// result has been taken. The user must write the data memory window
// registers over the cfg port only while the block is idle; the block does
// not enforce this. Index 0 is the window base, index 1 the window size.
module conv_descriptor_csr_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[1:0], is_set_op[2], set_slot[6:3], payload[70:7], zero[71]
  input  logic [71:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // accepted[0], committed[1], error_code[6:2], busy_res[7], complete_done[8],
  // read_data[72:9], output_height[88:73], output_width[104:89], zero[111:105]
  output logic [111:0] m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [32:0]  cfg_wdata
);
  import cdcc_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic [OutWidth-1:0] dp_tdata;

  cdcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  cdcc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (dp_tdata)
  );

  // Datapath packs height above width; swap so height sits low as the port lists.
  assign m_tdata = {dp_tdata[111:105], dp_tdata[88:73], dp_tdata[104:89],
                    dp_tdata[72:0]};

  // One item in flight: no accept right after an accept.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while previous one in flight");

  // An emit always presents a result on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("emitted result not presented");

  // At most one phase command at a time.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.decode, cmd.mul, cmd.range, cmd.ovlp, cmd.emit}))
    else $error("controller issued overlapping commands");

endmodule

// ----- rtl/core/cdcc_ctrl.sv -----
// Sequencer of the descriptor checker: accept, decode, size products,
// range pass, overlap pass, emit. Depends on cdcc_pkg.
module cdcc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output cdcc_pkg::cmd_t    cmd,
  input  cdcc_pkg::status_t status
);
  import cdcc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_RANGE  = 6'b001000,
    ST_OVLP   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [2:0] step, step_next;

  assign s_tready = (state == ST_IDLE) && !status.out_full;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.step   = step;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        step_next  = '0;
        state_next = status.chk_go ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (step == MulLast) begin
          step_next  = '0;
          state_next = ST_RANGE;
        end else begin
          step_next = step + 3'd1;
        end
      end
      ST_RANGE: begin
        cmd.range = 1'b1;
        if (status.fail) begin
          state_next = ST_DONE;
        end else if (step == RangeLast) begin
          step_next  = '0;
          state_next = ST_OVLP;
        end else begin
          step_next = step + 3'd1;
        end
      end
      ST_OVLP: begin
        cmd.ovlp = 1'b1;
        if (status.fail || step == OvlpLast) begin
          state_next = ST_DONE;
        end else begin
          step_next = step + 3'd1;
        end
      end
      ST_DONE: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ----- rtl/core/cdcc_dp.sv -----
// Datapath of the descriptor checker: shadow words, field checks, shared
// multiplier, range and overlap compares, output register. Depends on cdcc_pkg.
module cdcc_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  cdcc_pkg::cmd_t                  cmd,
  output cdcc_pkg::status_t               status,
  input  logic [cdcc_pkg::InWidth-1:0]    s_tdata,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [32:0]                     cfg_wdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cdcc_pkg::OutWidth-1:0]   m_tdata
);
  import cdcc_pkg::*;

  // Latched item
  op_e_t       op;
  logic        set_op;
  logic [3:0]  slot;
  logic [63:0] payload;

  // Architectural state
  logic [63:0] shadow [3];
  logic [2:0]  slot_mask;
  logic        busy;
  logic [31:0] dm_base;
  logic [32:0] dm_size;

  // Check working registers
  err_e_t                err;
  logic [16:0]           hh, ww;
  logic [21:0]           pa;
  logic [33:0]           pb;
  logic [SizeWidth-1:0]  size0, size3;
  logic [32:0]           ends [4];

  // Descriptor fields
  logic [63:0] w0, w1, w2, c;
  logic [15:0] ih, iw, bn;
  logic [5:0]  ic;
  logic [4:0]  oc;
  logic        pad, sm1;
  logic [16:0] ph, pw, hh_calc, ww_calc;
  logic [33:0] dm_end;
  logic [2:0]  next_slot;
  err_e_t      check_err, decode_err;

  assign w0 = shadow[0];
  assign w1 = shadow[1];
  assign w2 = shadow[2];
  assign c  = payload;
  assign ih  = w2[15:0];
  assign iw  = w2[31:16];
  assign bn  = w2[47:32];
  assign ic  = w2[53:48];
  assign oc  = w2[58:54];
  assign pad = c[4];
  assign sm1 = c[5];
  assign ph  = {1'b0, ih} + {15'd0, pad, 1'b0};
  assign pw  = {1'b0, iw} + {15'd0, pad, 1'b0};
  assign hh_calc = ((ph - 17'd3) >> sm1) + 17'd1;
  assign ww_calc = ((pw - 17'd3) >> sm1) + 17'd1;
  assign dm_end  = {2'b0, dm_base} + {1'b0, dm_size};

  always_comb begin
    if (!slot_mask[0])      next_slot = 3'd1;
    else if (!slot_mask[1]) next_slot = 3'd2;
    else if (!slot_mask[2]) next_slot = 3'd3;
    else                    next_slot = 3'd4;
  end

  // Field checks of slot 4 that need no products, in priority order.
  always_comb begin
    check_err = ERR_NONE;
    if (w2[63:59] != '0)                          check_err = ERR_RSV_SHAPE;
    else if (c[30:14] != '0 || c[55:32] != '0)    check_err = ERR_RSV_CTRL;
    else if (!c[31])                              check_err = ERR_START;
    else if (c[63:56] != ConvMagic)               check_err = ERR_MAGIC;
    else if (c[3:0] != 4'd1)                      check_err = ERR_ABI;
    else if (c[10:6] > 5'd23)                     check_err = ERR_CUTBIT;
    else if (c[13:11] != 3'd3)                    check_err = ERR_KSIZE;
    else if (ih == '0 || iw == '0 || bn == '0 || ic == '0 || oc == '0 ||
             oc > 5'd16 || ph < 17'd3 || pw < 17'd3)
                                                  check_err = ERR_SHAPE;
    else if (dm_size == '0 || dm_end > 34'h1_0000_0000)
                                                  check_err = ERR_DMEM;
    else if (w1[0])                               check_err = ERR_BIAS;
  end

  always_comb begin
    decode_err = ERR_NONE;
    if (op == OP_SLOT) begin
      if (busy)                               decode_err = ERR_BUSY;
      else if (!set_op || slot > 4'd4)        decode_err = ERR_UNSUP;
      else if (slot != {1'b0, next_slot})     decode_err = ERR_SEQ;
      else if (slot == 4'd4)                  decode_err = check_err;
    end
  end

  // Shared multiplier, one product per step.
  logic [33:0] mul_x;
  logic [21:0] mul_y;
  logic [55:0] mul_p;

  always_comb begin
    case (cmd.step)
      3'd0:    begin mul_x = {18'd0, bn};  mul_y = {16'd0, ic};  end
      3'd1:    begin mul_x = {18'd0, ih};  mul_y = {6'd0, iw};   end
      3'd2:    begin mul_x = pb;           mul_y = pa;           end
      3'd3:    begin mul_x = {18'd0, bn};  mul_y = {17'd0, oc};  end
      3'd4:    begin mul_x = {17'd0, hh};  mul_y = {5'd0, ww};   end
      default: begin mul_x = pb;           mul_y = pa;           end
    endcase
  end
  assign mul_p = {22'd0, mul_x} * {34'd0, mul_y};

  // Range pass: one tensor per step.
  logic [31:0]          rng_begin;
  logic [SizeWidth-1:0] rng_size;
  logic [10:0]          icoc;
  logic [54:0]          rng_end;
  err_e_t               rng_err;

  assign icoc = {5'd0, ic} * {6'd0, oc};

  always_comb begin
    case (cmd.step[1:0])
      2'd0:    begin rng_begin = w0[31:0];  rng_size = size0; end
      2'd1:    begin
        rng_begin = w0[63:32];
        rng_size  = {{(SizeWidth-15){1'b0}}, {1'b0, icoc, 3'b0} + {4'd0, icoc}};
      end
      2'd2:    begin
        rng_begin = w1[31:0];
        rng_size  = {{(SizeWidth-6){1'b0}}, oc, 1'b0};
      end
      default: begin rng_begin = w1[63:32]; rng_size = size3; end
    endcase
  end

  assign rng_end = {23'd0, rng_begin} + {1'b0, rng_size};

  always_comb begin
    rng_err = ERR_NONE;
    if (rng_end > 55'h1_0000_0000)                                  rng_err = ERR_ADDR_OVF;
    else if (rng_begin < dm_base || rng_end > {21'd0, dm_end})      rng_err = ERR_ADDR_RANGE;
  end

  // Overlap pass: one pair per step.
  logic [1:0]  ov_i, ov_j;
  logic [32:0] beg_i, beg_j;
  logic        ov_hit;

  assign ov_i = pair_lo(cmd.step);
  assign ov_j = pair_hi(cmd.step);

  function automatic logic [32:0] begin_of(input logic [1:0] k,
                                           input logic [63:0] a,
                                           input logic [63:0] b);
    case (k)
      2'd0:    begin_of = {1'b0, a[31:0]};
      2'd1:    begin_of = {1'b0, a[63:32]};
      2'd2:    begin_of = {1'b0, b[31:0]};
      default: begin_of = {1'b0, b[63:32]};
    endcase
  endfunction

  assign beg_i  = begin_of(ov_i, w0, w1);
  assign beg_j  = begin_of(ov_j, w0, w1);
  assign ov_hit = (beg_i < ends[ov_j]) && (beg_j < ends[ov_i]);

  assign status.out_full = m_tvalid;
  assign status.chk_go   = (decode_err == ERR_NONE) && (op == OP_SLOT) && (slot == 4'd4);
  assign status.fail     = (cmd.range && rng_err != ERR_NONE) || (cmd.ovlp && ov_hit);

  // Result fields
  logic        acc, com, done, busy_next;
  logic [63:0] rd;
  logic [1:0]  sidx;

  assign sidx = slot[1:0] - 2'd1;
  assign acc  = (op == OP_SLOT) && (err == ERR_NONE);
  assign com  = acc && (slot == 4'd4);
  assign done = (op == OP_COMPLETE) && busy;
  assign rd   = (op == OP_READ && slot >= 4'd1 && slot <= 4'd3) ? shadow[sidx] : '0;

  always_comb begin
    busy_next = busy;
    case (op)
      OP_SLOT:     if (com) busy_next = 1'b1;
      OP_COMPLETE: busy_next = 1'b0;
      OP_CLEAR:    busy_next = 1'b0;
      default:     busy_next = busy;
    endcase
  end

  // Item, working and payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= op_e_t'(s_tdata[1:0]);
      set_op  <= s_tdata[2];
      slot    <= s_tdata[6:3];
      payload <= s_tdata[70:7];
    end
    if (cmd.decode) begin
      err <= decode_err;
      hh  <= hh_calc;
      ww  <= ww_calc;
    end
    if (cmd.mul) begin
      case (cmd.step)
        3'd0, 3'd3: pa    <= mul_p[21:0];
        3'd1, 3'd4: pb    <= mul_p[33:0];
        3'd2:       size0 <= mul_p[SizeWidth-1:0];
        default:    size3 <= mul_p[SizeWidth-1:0];
      endcase
    end
    if (cmd.range) begin
      ends[cmd.step[1:0]] <= rng_end[32:0];
      if (rng_err != ERR_NONE) err <= rng_err;
    end
    if (cmd.ovlp && ov_hit) err <= ERR_OVERLAP;
    if (cmd.emit) begin
      m_tdata <= {7'd0,
                  com ? hh[15:0] : 16'd0,
                  com ? ww[15:0] : 16'd0,
                  rd, done, busy_next,
                  (op == OP_SLOT) ? err : ERR_NONE,
                  com, acc};
    end
  end

  // The top level reorders so output_width lies above output_height as the port lists.
  // (here height occupies [104:89], width [88:73])

  // Control state and shadow words
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      busy      <= 1'b0;
      slot_mask <= '0;
      dm_base   <= '0;
      dm_size   <= '0;
      for (int k = 0; k < 3; k++) shadow[k] <= '0;
    end else begin
      if (cmd.emit)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == RegDmBase) dm_base <= cfg_wdata[31:0];
        if (cfg_index == RegDmSize) dm_size <= cfg_wdata;
      end
      if (cmd.emit) begin
        busy <= busy_next;
        if (op == OP_CLEAR || com) begin
          slot_mask <= '0;
          for (int k = 0; k < 3; k++) shadow[k] <= '0;
        end else if (acc) begin
          shadow[sidx]    <= payload;
          slot_mask[sidx] <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- bench/tb_conv_descriptor_csr_checker.sv -----
// Self-checking bench for conv_descriptor_csr_checker: directed table, then random jobs.
// Depends on cdcc_pkg and the block's RTL; predicts each result in-bench.
module tb_conv_descriptor_csr_checker;
  import cdcc_pkg::*;

  localparam int IdleLimit  = 5000;
  localparam int DrainWait  = 30;
  localparam logic [63:0] AddrTop = 64'h1_0000_0000;

  // Packed like m_tdata: accepted in bit 0 upward.
  typedef struct packed {
    logic [15:0] ow;
    logic [15:0] oh;
    logic [63:0] rd;
    logic        done;
    logic        busy;
    err_e_t      err;
    logic        com;
    logic        acc;
  } check_res_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    op_e_t       op;
    logic        set_op;
    logic [3:0]  slot;
    logic [63:0] payload;
    logic        typed;
    err_e_t      err;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [71:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_index = RegDmBase;
  logic [32:0]  cfg_wdata = '0;

  conv_descriptor_csr_checker DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_wdata
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow copy of the checker state and window registers.
  logic [63:0] win_base, win_size;
  logic [63:0] shadow_q [3];
  logic [2:0]  slot_mask;
  logic        job_running;
  logic [63:0] job_w [4];

  check_res_t pending_q [$];
  int  n_items, n_results, n_commits, n_errors, n_mismatch;
  bit  no_idle;

  function automatic err_e_t check_desc(input logic [63:0] w0, w1, w2, c,
                                        output logic [15:0] oh, ow);
    logic [63:0] ih, iw, bn, ic, oc, pad, sm1, ph, pw, hh, ww, dm_end;
    logic [63:0] lo [4];
    logic [63:0] hi [4];
    logic [63:0] sz [4];
    oh = '0;
    ow = '0;
    ih = 64'(w2[15:0]);  iw = 64'(w2[31:16]); bn = 64'(w2[47:32]);
    ic = 64'(w2[53:48]); oc = 64'(w2[58:54]);
    pad = 64'(c[4]); sm1 = 64'(c[5]);
    if (w2[63:59] != 0) return ERR_RSV_SHAPE;
    if (c[30:14] != 0 || c[55:32] != 0) return ERR_RSV_CTRL;
    if (!c[31]) return ERR_START;
    if (c[63:56] != ConvMagic) return ERR_MAGIC;
    if (c[3:0] != 4'd1) return ERR_ABI;
    if (c[10:6] > 23) return ERR_CUTBIT;
    if (c[13:11] != 3'd3) return ERR_KSIZE;
    if (ih == 0 || iw == 0 || bn == 0 || ic == 0 || ic > 63 || oc == 0 || oc > 16)
      return ERR_SHAPE;
    ph = ih + 2 * pad;
    pw = iw + 2 * pad;
    if (ph < 3 || pw < 3) return ERR_SHAPE;
    hh = (ph - 3) / (sm1 + 1) + 1;
    ww = (pw - 3) / (sm1 + 1) + 1;
    sz[0] = bn * ic * ih * iw;
    sz[1] = ic * 9 * oc;
    sz[2] = oc * 2;
    sz[3] = bn * oc * hh * ww;
    if (win_size == 0) return ERR_DMEM;
    dm_end = win_base + win_size;
    if (dm_end > AddrTop) return ERR_DMEM;
    if (w1[0]) return ERR_BIAS;
    lo[0] = 64'(w0[31:0]); lo[1] = 64'(w0[63:32]);
    lo[2] = 64'(w1[31:0]); lo[3] = 64'(w1[63:32]);
    for (int i = 0; i < 4; i++) begin
      hi[i] = lo[i] + sz[i];
      if (hi[i] > AddrTop) return ERR_ADDR_OVF;
      if (lo[i] < win_base || hi[i] > dm_end) return ERR_ADDR_RANGE;
    end
    for (int i = 0; i < 4; i++)
      for (int j = i + 1; j < 4; j++)
        if (lo[i] < hi[j] && lo[j] < hi[i]) return ERR_OVERLAP;
    oh = hh[15:0];
    ow = ww[15:0];
    return ERR_NONE;
  endfunction

  // Advance the shadow state by one item and return what the block must answer.
  task automatic predict_item(input op_e_t op, input logic set_op, input logic [3:0] slot,
                              input logic [63:0] payload, output check_res_t r);
    logic [3:0] next_slot;
    r = '0;
    case (op)
      OP_SLOT: begin
        next_slot = !slot_mask[0] ? 4'd1 : !slot_mask[1] ? 4'd2 : !slot_mask[2] ? 4'd3 : 4'd4;
        if (job_running) r.err = ERR_BUSY;
        else if (!set_op || slot > 4) r.err = ERR_UNSUP;
        else if (slot != next_slot) r.err = ERR_SEQ;
        else if (slot < 4) begin
          shadow_q[slot - 1] = payload;
          slot_mask[slot - 1] = 1'b1;
          r.acc = 1'b1;
        end else begin
          r.err = check_desc(shadow_q[0], shadow_q[1], shadow_q[2], payload, r.oh, r.ow);
          if (r.err == ERR_NONE) begin
            job_running = 1'b1;
            shadow_q = '{default: '0};
            slot_mask = '0;
            r.acc = 1'b1;
            r.com = 1'b1;
          end
        end
      end
      OP_COMPLETE: begin
        if (job_running) begin
          job_running = 1'b0;
          r.done = 1'b1;
        end
      end
      OP_READ: if (slot >= 1 && slot <= 3) r.rd = shadow_q[slot - 1];
      default: begin
        shadow_q = '{default: '0};
        slot_mask = '0;
        job_running = 1'b0;
      end
    endcase
    r.busy = (op == OP_CLEAR) ? 1'b0 : job_running;
  endtask

  // Offer one item; keep tvalid high into the next item when no gap is drawn.
  task automatic send_item(input op_e_t op, input logic set_op, input logic [3:0] slot,
                           input logic [63:0] payload, input logic typed = 1'b0,
                           input err_e_t typed_err = ERR_NONE);
    int gap;
    check_res_t r;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, payload, slot, set_op, op};
    do @(posedge clk); while (!s_tready);
    predict_item(op, set_op, slot, payload, r);
    if (typed) r.err = typed_err;
    pending_q.push_back(r);
    n_items++;
  endtask

  // Hold the sender until every answer is back, then let the check pipeline settle.
  task automatic drain_results();
    @(posedge clk);
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_window(input logic [31:0] base, input logic [32:0] size);
    cfg_we <= 1'b1;
    cfg_index <= RegDmBase;
    cfg_wdata <= {1'b0, base};
    @(posedge clk);
    cfg_index <= RegDmSize;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_base = 64'(base);
    win_size = 64'(size);
  endtask

  function automatic logic [63:0] ctrl_word(input logic pad, sm1, input logic [4:0] cut,
                                            input logic [2:0] ks, input logic [3:0] abi);
    return {ConvMagic, 24'h0, 1'b1, 17'h0, ks, cut, sm1, pad, abi};
  endfunction

  function automatic logic [63:0] shape_word(input logic [15:0] ih, iw, bn,
                                             input logic [5:0] ic, input logic [4:0] oc);
    return {5'b0, oc, ic, bn, iw, ih};
  endfunction

  // Lay out a legal-looking job inside the current window; corrupt it now and then.
  task automatic build_job();
    logic [15:0] ih, iw, bn;
    logic [5:0]  ic;
    logic [4:0]  oc;
    logic        pad, sm1;
    logic [63:0] p, hh, ww;
    logic [31:0] lo [4];
    logic [63:0] sz [4];
    int          wi, bi;
    pad = 1'($urandom_range(0, 1));
    sm1 = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 19) == 0) begin
      ih = 16'($urandom); iw = 16'($urandom); bn = 16'($urandom_range(1, 3));
    end else begin
      ih = 16'($urandom_range(1, 9)); iw = 16'($urandom_range(1, 9));
      bn = 16'($urandom_range(1, 2));
    end
    ic = 6'($urandom_range(1, 4));
    oc = 5'($urandom_range(1, 4));
    if ($urandom_range(0, 29) == 0) begin
      ic = 6'd63; oc = 5'd16;
    end
    hh = 64'((ih + 2 * pad >= 3) ? (ih + 2 * pad - 3) / (sm1 + 1) + 1 : 1);
    ww = 64'((iw + 2 * pad >= 3) ? (iw + 2 * pad - 3) / (sm1 + 1) + 1 : 1);
    sz[0] = 64'(bn) * 64'(ic) * 64'(ih) * 64'(iw);
    sz[1] = 64'(ic) * 64'd9 * 64'(oc);
    sz[2] = 64'(oc) * 64'd2;
    sz[3] = 64'(bn) * 64'(oc) * hh * ww;
    p = win_base + 64'($urandom_range(0, 64));
    for (int i = 0; i < 4; i++) begin
      if (i == 2) p[0] = 1'b0;
      lo[i] = p[31:0];
      p = (p + sz[i] + 64'($urandom_range(0, 32)) + 64'd1) & ~64'h1;
    end
    job_w[0] = {lo[1], lo[0]};
    job_w[1] = {lo[3], lo[2]};
    job_w[2] = shape_word(ih, iw, bn, ic, oc);
    job_w[3] = ctrl_word(pad, sm1, 5'($urandom_range(0, 23)), 3'd3, 4'd1);
    wi = $urandom_range(0, 3);
    bi = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0, 1, 2: job_w[wi][bi] = ~job_w[wi][bi];
      3: job_w[1][63:32] = job_w[0][31:0];
      4: job_w[0][63:32] = 32'hffff_ff00 | $urandom_range(0, 255);
      default: ;
    endcase
  endtask

  // Receiver: stall per item, compare each answer with the oldest prediction.
  initial begin
    int stall;
    check_res_t want, got;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = check_res_t'(m_tdata[104:0]);
      n_results++;
      if (pending_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result item %h", m_tdata);
      end else begin
        want = pending_q.pop_front();
        if (got.com) n_commits++;
        if (got.err != ERR_NONE) n_errors++;
        if (got !== want || m_tdata[111:105] !== '0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"mismatch item %0d: acc %b/%b com %b/%b err %0d/%0d busy %b/%b ",
                      "done %b/%b rd %h/%h oh %0d/%0d ow %0d/%0d (exp/got)"},
                     n_results, want.acc, got.acc, want.com, got.com, want.err, got.err,
                     want.busy, got.busy, want.done, got.done, want.rd, got.rd,
                     want.oh, got.oh, want.ow, got.ow);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= IdleLimit) begin
        $display("conv_descriptor_csr_checker test failed");
        $finish;
      end
    end
  end

  initial begin
    row_t rows [$];
    logic [63:0] w0, w1, w2, w3;
    logic [31:0] bases [7];
    logic [32:0] sizes [7];
    int target;

    win_base = '0;
    win_size = '0;
    shadow_q = '{default: '0};
    slot_mask = '0;
    job_running = 1'b0;

    // Small job: four tensors far apart, 4x4 input gives a 2x2 output.
    w0 = {32'h2000, 32'h1000};
    w1 = {32'h4000, 32'h3000};
    w2 = shape_word(16'd4, 16'd4, 16'd1, 6'd1, 5'd1);
    w3 = ctrl_word(1'b0, 1'b0, 5'd0, 3'd3, 4'd1);

    rows = '{
      '{ROW_ITEM, OP_READ,     1'b1, 4'd1,  '0,         1'b1, ERR_NONE},
      '{ROW_ITEM, OP_SLOT,     1'b0, 4'd1,  w0,         1'b1, ERR_UNSUP},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd15, w0,         1'b1, ERR_UNSUP},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd0,  w0,         1'b1, ERR_SEQ},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd2,  w1,         1'b1, ERR_SEQ},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd1,  w0,         1'b1, ERR_NONE},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd2,  w1,         1'b1, ERR_NONE},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd3,  w2,         1'b1, ERR_NONE},
      // window size is still zero after reset
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd4,  w3,         1'b1, ERR_DMEM},
      '{ROW_CFG,  OP_SLOT,     1'b0, 4'd0,  '0,         1'b0, ERR_NONE},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd4,  '1,         1'b1, ERR_RSV_CTRL},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd4,  '0,         1'b1, ERR_START},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd4,  w3 ^ (64'hc3 << 56), 1'b1, ERR_MAGIC},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd4,  w3 ^ 64'h3, 1'b1, ERR_ABI},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd4,  w3 | 64'h7c0, 1'b1, ERR_CUTBIT},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd4,  w3 ^ 64'h800, 1'b1, ERR_KSIZE},
      '{ROW_ITEM, OP_READ,     1'b0, 4'd3,  '0,         1'b0, ERR_NONE},
      '{ROW_ITEM, OP_READ,     1'b0, 4'd4,  '0,         1'b0, ERR_NONE},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd4,  w3,         1'b0, ERR_NONE},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd1,  w0,         1'b1, ERR_BUSY},
      '{ROW_ITEM, OP_COMPLETE, 1'b0, 4'd0,  '0,         1'b0, ERR_NONE},
      '{ROW_ITEM, OP_COMPLETE, 1'b0, 4'd0,  '0,         1'b0, ERR_NONE},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd1,  '1,         1'b0, ERR_NONE},
      '{ROW_ITEM, OP_CLEAR,    1'b1, 4'd15, '1,         1'b0, ERR_NONE},
      '{ROW_ITEM, OP_SLOT,     1'b1, 4'd4,  w3,         1'b1, ERR_SEQ}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain_results();
        write_window(32'h1000, 33'h1_0000);
      end else begin
        send_item(rows[i].op, rows[i].set_op, rows[i].slot, rows[i].payload,
                  rows[i].typed, rows[i].err);
      end
    end

    // Window settings per phase, extremes first.
    bases = '{32'h0, 32'hffff_f000, 32'h100, 32'hffff_ffff, 32'h0, 32'h8000_0000, 32'h0};
    sizes = '{33'h1_0000_0000, 33'h1000, 33'h1_0000_0000, 33'h1, 33'h0,
              33'h8000_0000, 33'h0};
    bases[6] = $urandom_range(0, 32'h7fff_ffff);
    sizes[6] = 33'($urandom_range(32'h800, 32'h4_0000));

    foreach (bases[ph]) begin
      drain_results();
      write_window(bases[ph], sizes[ph]);
      no_idle = (ph == 2);
      target = n_items + 290;
      while (n_items < target) begin
        if ($urandom_range(0, 99) < 15) begin
          send_item(op_e_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    4'($urandom_range(0, 15)), {$urandom, $urandom});
        end else begin
          if (job_running && $urandom_range(0, 9) != 0)
            send_item(OP_COMPLETE, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), '0);
          build_job();
          for (int s = 1; s <= 4; s++) begin
            if ($urandom_range(0, 9) == 0)
              send_item(OP_READ, 1'b0, 4'($urandom_range(0, 4)), '0);
            send_item(OP_SLOT, 1'b1, 4'(s), job_w[s - 1]);
          end
          if ($urandom_range(0, 19) == 0) send_item(OP_CLEAR, 1'b0, 4'd0, '0);
          // Now and then wait for the block to answer everything before going on.
          if ($urandom_range(0, 24) == 0) drain_results();
        end
      end
    end

    drain_results();
    $display("ran %0d items over %0d window settings: %0d jobs committed, %0d error answers",
             n_items, $size(bases) + 2, n_commits, n_errors);
    if (n_mismatch == 0 && pending_q.size() == 0) begin
      $display("conv_descriptor_csr_checker test passed");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("conv_descriptor_csr_checker test failed");
    end
    $finish;
  end

endmodule
